[hw/rtl/ccs_pkg.sv]
// Shared request codes and handle field widths for the compact count store.
package ccs_pkg;

   // Width of a handle field and of the count values carried on the streams.
   localparam int FIELD_BITS = 15;
   localparam int PORT_VALUE_BITS = 32;

   // Request codes carried on the request stream.
   typedef enum logic [1:0] {
      REQ_ENCODE  = 2'd0,
      REQ_DECODE  = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_ASSIGN  = 2'd3
   } req_code_type;

endpackage

[hw/rtl/compact_count_store_unit.sv]
// Compact count store: inline small counts, free-list value table for large ones.
// Responses are registered in the write-back state, which holds while a result waits.
// Requests are taken one at a time: a request cycle that reads the table
// (two read ports: free-list link and handle slot), then the write-back cycle.
// Reset: synchronous; the table is chained into a full free list by a sweep over
// every slot, during which req_tready stays low.
module compact_count_store_unit
   import ccs_pkg::*;
#(
   parameter int INLINE_LIMIT = 32767,
   parameter int TABLE_DEPTH  = 1024,
   parameter int VALUE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // value[31:0], dest_indirect[32], dest_field[47:33],
   // source_indirect[48], source_field[63:49]
   input  logic [63:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // handle_indirect[0], handle_field[15:1], value_out[47:16]
   output logic [47:0] rsp_tdata,
   // status[0]
   output logic        rsp_tuser
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int HW = $clog2(TABLE_DEPTH + 1);
   localparam logic [15:0] DEPTH_W = 16'(TABLE_DEPTH);
   localparam logic [HW-1:0] HEAD_EMPTY = HW'(TABLE_DEPTH);
   localparam logic [VALUE_BITS-1:0] DEPTH_V = VALUE_BITS'(TABLE_DEPTH);
   localparam logic [VALUE_BITS-1:0] LIMIT_V = VALUE_BITS'(INLINE_LIMIT);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;

   // Value table with one write port and two registered read ports.
   logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_a_addr;
   logic [AW-1:0]         rd_b_addr;
   logic [VALUE_BITS-1:0] rd_a_ff;
   logic [VALUE_BITS-1:0] rd_b_ff;

   // Captured request.
   req_code_type           rq_type_ff;
   logic [PORT_VALUE_BITS-1:0] rq_value_ff;
   logic                   rq_dind_ff;
   logic [FIELD_BITS-1:0]  rq_dfld_ff;
   logic                   rq_sind_ff;
   logic [FIELD_BITS-1:0]  rq_sfld_ff;
   logic                   rq_bok_ff;

   logic [HW-1:0] head_ff;
   logic [HW-1:0] head_in;
   logic [AW-1:0] init_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_hind_ff;
   logic [FIELD_BITS-1:0] rsp_hfld_ff;
   logic [PORT_VALUE_BITS-1:0] rsp_vout_ff;
   logic                  rsp_status_ff;

   logic                  hind_in;
   logic [FIELD_BITS-1:0] hfld_in;
   logic [PORT_VALUE_BITS-1:0] vout_in;
   logic                  status_in;

   logic                  accept;
   logic                  exec_go;
   logic                  head_ok;
   logic                  link_ok;
   logic                  d_ok;
   logic                  b_ok;
   logic [FIELD_BITS-1:0] b_field;
   logic [HW-1:0]         pop_head;
   logic [VALUE_BITS-1:0] src_val;
   logic [VALUE_BITS-1:0] enc_val;
   logic                  op_wr;
   logic [AW-1:0]         op_addr;
   logic [VALUE_BITS-1:0] op_data;

   // Request field unpacking.
   logic [PORT_VALUE_BITS-1:0] in_value;
   logic                       in_dind;
   logic [FIELD_BITS-1:0]      in_dfld;
   logic                       in_sind;
   logic [FIELD_BITS-1:0]      in_sfld;
   req_code_type               in_type;

   assign in_value = req_tdata[31:0];
   assign in_dind  = req_tdata[32];
   assign in_dfld  = req_tdata[47:33];
   assign in_sind  = req_tdata[48];
   assign in_sfld  = req_tdata[63:49];
   assign in_type  = req_code_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Read addresses: the free-list head on port A, the handle slot on port B.
   assign head_ok   = (head_ff < HEAD_EMPTY);
   assign b_field   = (in_type == REQ_DECODE) ? in_dfld : in_sfld;
   assign b_ok      = ({1'b0, b_field} < DEPTH_W);
   assign rd_en     = accept;
   assign rd_a_addr = head_ok ? head_ff[AW-1:0] : '0;
   assign rd_b_addr = b_ok ? b_field[AW-1:0] : '0;

   // Values seen in the write-back cycle.
   assign link_ok  = (rd_a_ff < DEPTH_V);
   assign pop_head = link_ok ? rd_a_ff[HW-1:0] : HEAD_EMPTY;
   assign src_val  = rq_bok_ff ? rd_b_ff : '0;
   assign d_ok     = ({1'b0, rq_dfld_ff} < DEPTH_W);
   assign enc_val  = VALUE_BITS'(rq_value_ff);

   // Operation decode for the write-back cycle.
   always_comb begin
      op_wr     = 1'b0;
      op_addr   = rq_dfld_ff[AW-1:0];
      op_data   = '0;
      head_in   = head_ff;
      hind_in   = 1'b0;
      hfld_in   = '0;
      vout_in   = '0;
      status_in = 1'b0;
      unique case (rq_type_ff)
         REQ_ENCODE: begin
            if (enc_val <= LIMIT_V) begin
               hfld_in = rq_value_ff[FIELD_BITS-1:0];
            end else if (head_ok) begin
               op_wr   = 1'b1;
               op_addr = head_ff[AW-1:0];
               op_data = enc_val;
               hind_in = 1'b1;
               hfld_in = FIELD_BITS'(head_ff);
               head_in = pop_head;
            end else begin
               status_in = 1'b1;
            end
         end
         REQ_DECODE: begin
            vout_in = rq_dind_ff ? PORT_VALUE_BITS'(src_val)
                                 : PORT_VALUE_BITS'(rq_dfld_ff);
         end
         REQ_RELEASE: begin
            if (rq_dind_ff && d_ok) begin
               op_wr   = 1'b1;
               op_data = VALUE_BITS'(head_ff);
               head_in = HW'(rq_dfld_ff);
            end
         end
         REQ_ASSIGN: begin
            priority if (rq_dind_ff && rq_sind_ff) begin
               // Slot to slot: copy the value.
               op_wr   = d_ok;
               op_data = src_val;
               hind_in = 1'b1;
               hfld_in = rq_dfld_ff;
            end else if (rq_dind_ff) begin
               // Inline onto a slot: the slot goes back on the free list.
               op_wr   = d_ok;
               op_data = VALUE_BITS'(head_ff);
               if (d_ok) begin
                  head_in = HW'(rq_dfld_ff);
               end
               hfld_in = rq_sfld_ff;
            end else if (rq_sind_ff) begin
               // Slot onto an inline: take a fresh slot for the copy.
               if (head_ok) begin
                  op_wr   = 1'b1;
                  op_addr = head_ff[AW-1:0];
                  op_data = src_val;
                  hind_in = 1'b1;
                  hfld_in = FIELD_BITS'(head_ff);
                  head_in = pop_head;
               end else begin
                  status_in = 1'b1;
                  hfld_in   = rq_dfld_ff;
               end
            end else begin
               hfld_in = rq_sfld_ff;
            end
         end
         default: begin
            op_wr = 1'b0;
         end
      endcase
   end

   // Write port: the reset sweep or the write-back of a request.
   always_comb begin
      if (state_ff == ST_INIT) begin
         wr_en   = 1'b1;
         wr_addr = init_ff;
         wr_data = (init_ff == '0) ? DEPTH_V : VALUE_BITS'(init_ff - 1'b1);
      end else begin
         wr_en   = exec_go && op_wr;
         wr_addr = op_addr;
         wr_data = op_data;
      end
   end

   // Table storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_a_addr];
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         rq_type_ff  <= in_type;
         rq_value_ff <= in_value;
         rq_dind_ff  <= in_dind;
         rq_dfld_ff  <= in_dfld;
         rq_sind_ff  <= in_sind;
         rq_sfld_ff  <= in_sfld;
         rq_bok_ff   <= b_ok;
      end
   end

   // Sequencer, free-list head and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         head_ff      <= HW'(TABLE_DEPTH - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !exec_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == LAST_SLOT) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_go) begin
                  head_ff       <= head_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_hind_ff   <= hind_in;
                  rsp_hfld_ff   <= hfld_in;
                  rsp_vout_ff   <= vout_in;
                  rsp_status_ff <= status_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_INIT;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_vout_ff, rsp_hfld_ff, rsp_hind_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The free-list head is a slot or the empty mark, never beyond.
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= HEAD_EMPTY)
      else $error("free-list head out of range");

   // Table writes only ever target existing slots.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < TABLE_DEPTH))
      else $error("table write beyond depth");

   // A transfer is always followed by the write-back cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("request not followed by write-back");

   // Only one request is in flight at a time.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC || state_ff == ST_INIT) |-> !req_tready)
      else $error("request taken while busy");

   // A finished write-back always presents a result.
   assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("result lost after write-back");

endmodule
